// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// hold expr on every clock outside reset
`define ITOA_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// require cons in the cycle after ante
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ITOA_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/itoa_pkg.sv =====
package itoa_pkg;

   localparam int ValueWidth = 64;
   localparam int DigitWidth = 4;
   localparam int DigitCount = 20;
   localparam int HexDigits  = ValueWidth / DigitWidth;
   localparam int BcdWidth   = DigitCount * DigitWidth;
   localparam int CntWidth   = $clog2(DigitCount + 1);
   localparam int BitsPerStep = DigitWidth;

   localparam logic [1:0] ActUdec   = 2'd0;
   localparam logic [1:0] ActSdec   = 2'd1;
   localparam logic [1:0] ActHex    = 2'd2;
   localparam logic [1:0] ActHexPfx = 2'd3;

   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharMinus  = 8'h2d;
   localparam logic [7:0] CharX      = 8'h78;

   localparam logic [DigitWidth-1:0] DecLimit = 4'd10;

   typedef logic [BcdWidth-1:0] bcd_type;

   function automatic logic [7:0] digit_char(input logic [DigitWidth-1:0] d,
                                             input logic upper);
      logic [7:0] dx;
      dx = {{(8-DigitWidth){1'b0}}, d};
      if (d < DecLimit) begin
         return CharZero + dx;
      end
      return (upper ? CharUpperA : CharLowerA) + dx - 8'd10;
   endfunction

endpackage

// ===== src/itoa_dabble.sv =====
module itoa_dabble
   import itoa_pkg::*;
(
   input  bcd_type                bcd,
   input  logic [BitsPerStep-1:0] bits,
   output bcd_type                bcd_next
);

   bcd_type acc;
   logic [DigitWidth-1:0] dig;

   always_comb begin
      acc = bcd;
      dig = '0;
      for (int k = 0; k < BitsPerStep; k++) begin
         for (int i = 0; i < DigitCount; i++) begin
            dig = acc[i*DigitWidth +: DigitWidth];
            if (dig >= 4'd5) begin
               acc[i*DigitWidth +: DigitWidth] = dig + 4'd3;
            end
         end
         acc = {acc[BcdWidth-2:0], bits[BitsPerStep-1-k]};
      end
      bcd_next = acc;
   end

endmodule

// ===== src/integer_to_ascii_converter.sv =====
// Converts a 64-bit value to ASCII text, one character per rsp_valid pulse, most
// significant first, rsp_last on the final one. The receiver cannot stall: every
// character shows for exactly one cycle. busy stays high from start until the
// last character is registered. Decimal modes run a shift-and-add-3 unit four
// bits per cycle over all 64 bits, then drop leading zero digits one at a time,
// then send a minus sign for a negative signed value before the digits. Hex modes
// skip conversion but still drop leading zeros; the 0x prefix comes first.
`include "assert_macros.svh"

module integer_to_ascii_converter
   import itoa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [ValueWidth-1:0] req_value,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_PRE  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [ValueWidth-1:0] mag_ff, mag_in;
   bcd_type               dig_ff, dig_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic [3:0]            step_ff, step_in;
   logic [1:0]            pre_ff, pre_in;
   logic                  pre_hex_ff, pre_hex_in;
   logic                  upper_ff, upper_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   bcd_type               dabble_out;
   logic                  accept;
   logic                  neg;
   logic [DigitWidth-1:0] top_digit;

   itoa_dabble u_dabble (
      .bcd      (dig_ff),
      .bits     (mag_ff[ValueWidth-1 -: BitsPerStep]),
      .bcd_next (dabble_out)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign neg       = (req_action == ActSdec) && req_value[ValueWidth-1];
   assign top_digit = dig_ff[BcdWidth-1 -: DigitWidth];

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'b0, upper_ff} : 32'b0;

   always_comb begin
      upper_in = upper_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         upper_in = pwdata[0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      pre_in       = pre_ff;
      pre_hex_in   = pre_hex_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pre_hex_in = (req_action == ActHexPfx);
               pre_in     = (req_action == ActHexPfx) ? 2'd2 : (neg ? 2'd1 : 2'd0);
               step_in    = '0;
               if ((req_action == ActHex) || (req_action == ActHexPfx)) begin
                  dig_in   = {req_value, {(BcdWidth-ValueWidth){1'b0}}};
                  cnt_in   = CntWidth'(HexDigits);
                  state_in = ST_SKIP;
               end else begin
                  mag_in   = neg ? (~req_value + 1'b1) : req_value;
                  dig_in   = '0;
                  cnt_in   = CntWidth'(DigitCount);
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dig_in  = dabble_out;
            mag_in  = {mag_ff[ValueWidth-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_digit == '0) && (cnt_ff > CntWidth'(1))) begin
               dig_in = {dig_ff[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = (pre_ff != 2'd0) ? ST_PRE : ST_EMIT;
            end
         end
         ST_PRE: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = pre_hex_ff ? ((pre_ff == 2'd2) ? CharZero : CharX) : CharMinus;
            pre_in       = pre_ff - 2'd1;
            if (pre_ff == 2'd1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_char(top_digit, upper_ff);
            rsp_last_in  = (cnt_ff == CntWidth'(1));
            dig_in       = {dig_ff[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CntWidth'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upper_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         cnt_ff       <= '0;
         pre_ff       <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         upper_ff     <= upper_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         cnt_ff       <= cnt_in;
         pre_ff       <= pre_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      dig_ff      <= dig_in;
      pre_hex_ff  <= pre_hex_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   `ITOA_ASSERT_NEXT(a_start_busy, clock, reset, accept, busy, "transfer accepted but block not busy")
   `ITOA_ASSERT_NEXT(a_idle_quiet, clock, reset, !busy, !rsp_valid, "character emitted while idle")
   `ITOA_ASSERT_ALWAYS(a_last_valid, clock, reset, !rsp_last || rsp_valid, "last without strobe")
   `ITOA_ASSERT_ALWAYS(a_emit_cnt, clock, reset, (state_ff != ST_EMIT) || (cnt_ff != '0), "emit with no digits left")

endmodule
